[hw/rtl/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants of the odometry core
// CORDIC arctangent table, register indexes and controller command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;

    localparam int TAB_LEN = 30;
    localparam logic [31:0] GAIN_Q30 = 32'd652032875;

    localparam logic [1:0] REG_ANGLE_PER_MM = 2'd0;
    localparam logic [1:0] REG_LEFT_IS_REF  = 2'd1;
    localparam logic [1:0] REG_UPDATE_RATE  = 2'd2;

    // Input actions
    localparam logic ACT_LATCH  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933407;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input item, form deltas
        logic latch_prev; // action 0: store positions only
        logic turn;       // form saturated heading increment
        logic cordic_init_pose; // seed CORDIC with old heading
        logic cordic_init_half; // seed CORDIC with half new heading
        logic cordic_iter;
        logic mul_pose;   // products sum*cos, sum*sin
        logic commit;     // update pose and heading
        logic finish;     // capture quaternion and speeds
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
    } t_status;

endpackage
`default_nettype wire

[hw/rtl/ddo_ctrl.sv]
// ----------------------------------------------------------------------------
// ddo_ctrl: sequencer of the odometry core
// Steps one transaction through turn, two CORDIC passes and result capture.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  wire            i_action,
    input  wire            i_reads_ok,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    input  ddo_pkg::t_status i_status,
    output ddo_pkg::t_cmd  o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TURN  = 8'b0000_0010,
        S_COR1  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_COMM  = 8'b0001_0000,
        S_COR2  = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc && i_reads_ok) begin
                    if (i_action == ddo_pkg::ACT_UPDATE) begin
                        o_cmd.load = 1'b1;
                        n_state = S_TURN;
                    end else begin
                        o_cmd.latch_prev = 1'b1;
                    end
                end
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                o_cmd.cordic_init_pose = 1'b1;
                n_state = S_COR1;
            end
            S_COR1: begin
                if (!i_status.cordic_done) o_cmd.cordic_iter = 1'b1;
                else n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_pose = 1'b1;
                n_state = S_COMM;
            end
            S_COMM: begin
                o_cmd.commit = 1'b1;
                n_state = S_COR2;
            end
            S_COR2: begin
                if (!i_status.cordic_done) o_cmd.cordic_iter = 1'b1;
                else n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // second CORDIC pass is seeded in the commit cycle
        if (r_state == S_COMM) o_cmd.cordic_init_half = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

[hw/rtl/ddo_datapath.sv]
// ----------------------------------------------------------------------------
// ddo_datapath: arithmetic and state of the odometry core
// Holds pose and previous positions; shares one iterative CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_datapath #(
    parameter int ANGLE_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 30
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ddo_pkg::t_cmd       i_cmd,
    output ddo_pkg::t_status    o_status,
    input  wire signed [31:0]   i_left_pos_mm,
    input  wire signed [31:0]   i_right_pos_mm,
    input  wire [39:0]          i_angle_per_mm,
    input  wire                 i_left_is_reference,
    input  wire [9:0]           i_update_rate_hz,
    output logic signed [63:0]  o_pos_x,
    output logic signed [63:0]  o_pos_y,
    output logic signed [31:0]  o_heading,
    output logic signed [31:0]  o_quat_z,
    output logic [30:0]         o_quat_w,
    output logic signed [42:0]  o_linear_speed,
    output logic signed [41:0]  o_angular_speed
);
    localparam int NITER = (TRIG_FRAC_BITS < ddo_pkg::TAB_LEN) ?
                           TRIG_FRAC_BITS : ddo_pkg::TAB_LEN;
    localparam int SH    = TRIG_FRAC_BITS - 15;
    localparam int QS    = 30 - TRIG_FRAC_BITS;
    localparam logic [31:0] AMASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
    localparam logic [32:0] GAIN2 = {ddo_pkg::GAIN_Q30, 1'b0} >> QS;
    localparam logic signed [33:0] X0 = 34'($unsigned(GAIN2 + 33'd1) >> 1);
    localparam logic signed [33:0] ONE = 34'sd1 <<< TRIG_FRAC_BITS;

    logic [31:0]        r_prev_l, r_prev_r, r_head;
    logic [63:0]        r_px, r_py;
    logic signed [33:0] r_sum, r_diff;
    logic signed [32:0] r_dth;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [4:0]         r_it;
    logic               r_flip;
    logic signed [67:0] r_pc, r_ps;

    // --- deltas and turn
    logic [31:0] dl_u, dr_u;
    logic signed [33:0] dl, dr, dif;
    logic [33:0] mag_in;
    logic [53:0] hi;
    logic [54:0] lo;
    logic [58:0] mag;
    logic [30:0] mag_sat;

    assign dl_u = i_left_pos_mm  - r_prev_l;
    assign dr_u = i_right_pos_mm - r_prev_r;
    assign dl = 34'(signed'(dl_u));
    assign dr = 34'(signed'(dr_u));
    assign dif = i_left_is_reference ? (dl - dr) : (dr - dl);

    assign mag_in = r_diff[33] ? 34'(-r_diff) : 34'(r_diff);
    assign hi  = mag_in * i_angle_per_mm[39:20];
    assign lo  = mag_in * i_angle_per_mm[19:0] + 55'h8000;
    assign mag = {1'b0, hi, 4'b0} + 59'(lo >> 16);
    assign mag_sat = (mag > 59'h7FFF_FFFF) ? 31'h7FFF_FFFF : mag[30:0];

    // --- CORDIC
    logic [31:0] seed_ang, ang_m, ang_f;
    logic        seed_flip;
    logic [31:0] new_head, half_head;
    logic signed [33:0] dx, dy, at, cc, cs;

    assign new_head  = r_head + 32'(r_dth);
    assign half_head = {new_head[31], new_head[31:1]};
    assign seed_ang  = i_cmd.cordic_init_half ? half_head : r_head;
    assign ang_m     = seed_ang & AMASK;
    assign seed_flip = ang_m[31] ^ ang_m[30];
    assign ang_f     = seed_flip ? (ang_m + 32'h8000_0000) : ang_m;
    assign dx = r_cy >>> r_it;
    assign dy = r_cx >>> r_it;
    assign at = 34'(ddo_pkg::atan_entry(r_it));
    assign o_status.cordic_done = (r_it == 5'(NITER));

    function automatic logic signed [33:0] clamp1(input logic signed [33:0] v,
                                                  input logic f);
        logic signed [33:0] c;
        c = (v > ONE) ? ONE : ((v < -ONE) ? -ONE : v);
        return f ? -c : c;
    endfunction

    assign cc = clamp1(r_cx, r_flip);
    assign cs = clamp1(r_cy, r_flip);

    function automatic logic [63:0] units(input logic signed [67:0] p);
        logic signed [67:0] t;
        if (SH > 0) t = (p + (68'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        else if (SH == 0) t = p;
        else t = p <<< 1;
        return t[63:0];
    endfunction

    logic signed [33:0] hc_w;
    logic signed [63:0] zq, wq;
    assign hc_w = cc[33] ? 34'sd0 : cc;
    assign zq = 64'(cs) <<< QS;
    assign wq = 64'(hc_w) <<< QS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= '0; r_prev_r <= '0; r_head <= '0;
            r_px <= '0; r_py <= '0;
            r_it <= '0;
        end else begin
            if (i_cmd.latch_prev || i_cmd.load) begin
                r_prev_l <= i_left_pos_mm;
                r_prev_r <= i_right_pos_mm;
            end
            if (i_cmd.load) begin
                r_sum  <= dl + dr;
                r_diff <= dif;
            end
            if (i_cmd.turn)
                r_dth <= r_diff[33] ? -33'(signed'({2'b0, mag_sat}))
                                    : 33'(signed'({2'b0, mag_sat}));
            if (i_cmd.cordic_init_pose || i_cmd.cordic_init_half) begin
                r_cx <= X0; r_cy <= '0; r_cz <= 34'(signed'(ang_f));
                r_flip <= seed_flip; r_it <= '0;
            end else if (i_cmd.cordic_iter) begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - dx; r_cy <= r_cy + dy; r_cz <= r_cz - at;
                end else begin
                    r_cx <= r_cx + dx; r_cy <= r_cy - dy; r_cz <= r_cz + at;
                end
                r_it <= r_it + 5'd1;
            end
            if (i_cmd.mul_pose) begin
                r_pc <= r_sum * cc;
                r_ps <= r_sum * cs;
            end
            if (i_cmd.commit) begin
                r_px <= r_px + units(r_pc);
                r_py <= r_py + units(r_ps);
                r_head <= new_head;
            end
            if (i_cmd.finish) begin
                o_pos_x <= r_px; o_pos_y <= r_py; o_heading <= r_head;
                o_quat_z <= zq[31:0];
                o_quat_w <= wq[30:0];
                o_linear_speed  <= 43'(r_sum * $signed({1'b0, i_update_rate_hz}));
                o_angular_speed <= 42'(r_dth * $signed({1'b0, i_update_rate_hz}));
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/diff_drive_odometry_core.sv]
// ----------------------------------------------------------------------------
// diff_drive_odometry_core: differential drive odometry
// Integrates wheel encoder positions into pose, heading and speeds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries action, both wheel positions
//   and a reads-ok flag. A transaction with reads_ok low is dropped; action 0
//   only latches the positions. Both finish in the accept cycle.
//   Action 1 runs the turn step, a CORDIC pass on the old heading, the pose
//   products and commit, then a CORDIC pass on half the new heading. The
//   result is captured and shown on o_out_valid; both passes share one
//   iterative CORDIC unit.
//   One transaction is in flight at a time. The next one is taken the cycle
//   after the result is accepted. While the receiver stalls the result holds
//   and the input stays not ready.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_wdata) are taken at
//   any edge; write them only while idle.
//   Reset clears pose, heading, previous positions and loads register
//   defaults (angle_per_mm 0, left_is_reference 0, update_rate_hz 50).
// ----------------------------------------------------------------------------
`default_nettype none
module diff_drive_odometry_core #(
    parameter int ANGLE_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 30
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_index,
    input  wire [39:0]          i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_action,
    input  wire signed [31:0]   i_left_pos_mm,
    input  wire signed [31:0]   i_right_pos_mm,
    input  wire                 i_reads_ok,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic signed [63:0]  o_pos_x,
    output logic signed [63:0]  o_pos_y,
    output logic signed [31:0]  o_heading,
    output logic signed [31:0]  o_quat_z,
    output logic [30:0]         o_quat_w,
    output logic signed [42:0]  o_linear_speed,
    output logic signed [41:0]  o_angular_speed
);
    logic [39:0] r_angle_per_mm;
    logic        r_left_is_ref;
    logic [9:0]  r_rate;
    ddo_pkg::t_cmd    cmd;
    ddo_pkg::t_status st;

    // Hold configuration registers; write by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_per_mm <= '0;
            r_left_is_ref  <= 1'b0;
            r_rate         <= 10'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ddo_pkg::REG_ANGLE_PER_MM: r_angle_per_mm <= i_cfg_wdata;
                ddo_pkg::REG_LEFT_IS_REF:  r_left_is_ref  <= i_cfg_wdata[0];
                ddo_pkg::REG_UPDATE_RATE:  r_rate         <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    ddo_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_reads_ok(i_reads_ok),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(st), .o_cmd(cmd)
    );

    ddo_datapath #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(st),
        .i_left_pos_mm(i_left_pos_mm), .i_right_pos_mm(i_right_pos_mm),
        .i_angle_per_mm(r_angle_per_mm), .i_left_is_reference(r_left_is_ref),
        .i_update_rate_hz(r_rate),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_heading(o_heading),
        .o_quat_z(o_quat_z), .o_quat_w(o_quat_w),
        .o_linear_speed(o_linear_speed), .o_angular_speed(o_angular_speed)
    );
endmodule
`default_nettype wire

[test/tb_diff_drive_odometry_core.sv]
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_core: self-checking bench for the odometry core
// Drives wheel-position transactions through several register settings and
// checks every pose result against a cycle-free predictor of the core.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_diff_drive_odometry_core;

    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   SETTLE_CYCLES  = 100;
    localparam int   HOLD_CYCLES    = 400;
    localparam longint TRIG_ONE     = 64'sd1 << 30;

    typedef struct {
        logic        action;
        logic [31:0] left_mm;
        logic [31:0] right_mm;
        logic        reads_ok;
    } t_wheel_item;

    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
        logic [31:0] heading;
        logic [31:0] quat_z;
        logic [30:0] quat_w;
        logic [42:0] lin_speed;
        logic [41:0] ang_speed;
    } t_pose_result;

    // Arctangent of 2^-i as a 32-bit binary angle
    localparam logic [31:0] ATAN_BAM [30] = '{
        32'd536870912, 32'd316933407, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [39:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [31:0] left_pos;
    logic [31:0] right_pos;
    logic        reads_ok;
    logic        out_valid;
    logic        out_ready;
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] quat_z;
    logic [30:0]        quat_w;
    logic signed [42:0] linear_speed;
    logic signed [41:0] angular_speed;

    // Predictor state and register shadow
    logic [31:0] odo_prev_left, odo_prev_right, odo_heading;
    logic [63:0] odo_x, odo_y;
    logic [39:0] odo_angle_per_mm;
    logic        odo_left_ref;
    logic [9:0]  odo_rate_hz;

    t_wheel_item  wheel_q[$];
    t_pose_result pose_q[$];
    int errors;
    int hold_req, hold_seen, hold_left;
    int send_gap, recv_gap;
    bit no_idle;
    int idle_cycles;
    logic [31:0] gen_left, gen_right;

    diff_drive_odometry_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_action(action), .i_left_pos_mm(left_pos), .i_right_pos_mm(right_pos),
        .i_reads_ok(reads_ok),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_heading(heading),
        .o_quat_z(quat_z), .o_quat_w(quat_w),
        .o_linear_speed(linear_speed), .o_angular_speed(angular_speed)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Rotation-mode CORDIC on a binary angle; results in Q1.30
    function automatic void trig_of(input logic [31:0] ang, output longint c,
                                    output longint s);
        longint x, y, z, dx, dy;
        logic flip;
        flip = ang[31] ^ ang[30];
        // fold the back half-plane onto the front one, negate at the end
        if (flip) ang = ang + 32'h8000_0000;
        z = longint'($signed(ang));
        x = 64'sd652032875;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_BAM[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_BAM[i]);
            end
        end
        if (x > TRIG_ONE) x = TRIG_ONE;
        if (x < -TRIG_ONE) x = -TRIG_ONE;
        if (y > TRIG_ONE) y = TRIG_ONE;
        if (y < -TRIG_ONE) y = -TRIG_ONE;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Advance the odometry by one accepted transaction
    function automatic bit integrate_wheels(input t_wheel_item it,
                                            output t_pose_result res);
        longint dl, dr, sum, diff, dth, c, s, hc, hs, w, lin, ang;
        logic [63:0] m, hi, lo, mag;
        logic [31:0] half;
        logic neg;
        res = '{default: '0};
        if (!it.reads_ok) return 0;
        if (it.action == ddo_pkg::ACT_LATCH) begin
            odo_prev_left = it.left_mm;
            odo_prev_right = it.right_mm;
            return 0;
        end
        dl = longint'($signed(it.left_mm - odo_prev_left));
        dr = longint'($signed(it.right_mm - odo_prev_right));
        sum = dl + dr;
        diff = dr - dl;
        if (odo_left_ref) diff = -diff;
        neg = diff < 0;
        m = neg ? -diff : diff;
        hi = m * 64'(odo_angle_per_mm >> 20);
        lo = m * 64'(odo_angle_per_mm[19:0]) + 64'h8000;
        mag = (hi << 4) + (lo >> 16);
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        dth = neg ? -longint'(mag) : longint'(mag);

        trig_of(odo_heading, c, s);
        odo_x = odo_x + 64'((sum * c + 64'sd16384) >>> 15);
        odo_y = odo_y + 64'((sum * s + 64'sd16384) >>> 15);
        odo_heading = odo_heading + dth[31:0];
        odo_prev_left = it.left_mm;
        odo_prev_right = it.right_mm;

        half = $signed(odo_heading) >>> 1;
        trig_of(half, hc, hs);
        w = hc < 0 ? 0 : hc;
        lin = sum * longint'(odo_rate_hz);
        ang = dth * longint'(odo_rate_hz);
        res.x = odo_x;
        res.y = odo_y;
        res.heading = odo_heading;
        res.quat_z = hs[31:0];
        res.quat_w = w[30:0];
        res.lin_speed = lin[42:0];
        res.ang_speed = ang[41:0];
        return 1;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $time);
        errors++;
    endtask

    // Driver: present the front of the queue, pop it on the accepting edge
    always @(posedge clk) begin
        logic busy;
        t_pose_result res;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            busy = in_valid;
            if (in_valid && in_ready) begin
                busy = 1'b0;
                if (integrate_wheels(wheel_q[0], res)) pose_q.push_back(res);
                void'(wheel_q.pop_front());
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (wheel_q.size() > 0) begin
                    action <= wheel_q[0].action;
                    left_pos <= wheel_q[0].left_mm;
                    right_pos <= wheel_q[0].right_mm;
                    reads_ok <= wheel_q[0].reads_ok;
                    busy = 1'b1;
                    send_gap = no_idle ? 0 : pick_gap();
                end
            end
            in_valid <= busy;
        end
    end

    // Monitor: check each result transaction, stall the output at random
    always @(posedge clk) begin
        logic rdy;
        t_pose_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (pose_q.size() == 0) begin
                    $display("UNEXPECTED result transaction at %0t", $time);
                    errors++;
                end else begin
                    want = pose_q.pop_front();
                    if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
                    if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
                    if (heading !== want.heading)
                        report_mismatch("heading", 64'(heading), 64'(want.heading));
                    if (quat_z !== want.quat_z)
                        report_mismatch("quat_z", 64'(quat_z), 64'(want.quat_z));
                    if (quat_w !== want.quat_w)
                        report_mismatch("quat_w", 64'(quat_w), 64'(want.quat_w));
                    if (linear_speed !== want.lin_speed)
                        report_mismatch("linear_speed", 64'(linear_speed),
                                        64'(want.lin_speed));
                    if (angular_speed !== want.ang_speed)
                        report_mismatch("angular_speed", 64'(angular_speed),
                                        64'(want.ang_speed));
                end
            end
            // a long hold-off lets the core fill up and block its input
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                recv_gap = no_idle ? 0 : pick_gap();
            end
            out_ready <= rdy;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ddo_pkg::REG_ANGLE_PER_MM: odo_angle_per_mm = val;
            ddo_pkg::REG_LEFT_IS_REF:  odo_left_ref = val[0];
            ddo_pkg::REG_UPDATE_RATE:  odo_rate_hz = val[9:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [39:0] apm, input logic lref,
                             input logic [9:0] rate);
        write_reg(ddo_pkg::REG_ANGLE_PER_MM, apm);
        write_reg(ddo_pkg::REG_LEFT_IS_REF, {39'd0, lref});
        write_reg(ddo_pkg::REG_UPDATE_RATE, {30'd0, rate});
    endtask

    task automatic push_item(input logic act, input logic [31:0] l,
                             input logic [31:0] r, input logic ok);
        wheel_q.push_back('{action: act, left_mm: l, right_mm: r, reads_ok: ok});
    endtask

    // Hold until every transaction is accepted and every result is back
    task automatic drain();
        while (wheel_q.size() != 0 || in_valid || pose_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly smooth driving from a latched start, with noise mixed in
    task automatic queue_random(input int n);
        int r;
        logic [31:0] l, rr;
        push_item(ddo_pkg::ACT_LATCH, gen_left, gen_right, 1'b1);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                gen_left = gen_left + 32'($signed($urandom_range(0, 800)) - 400);
                gen_right = gen_right + 32'($signed($urandom_range(0, 800)) - 400);
                push_item(ddo_pkg::ACT_UPDATE, gen_left, gen_right, 1'b1);
            end else if (r < 80) begin
                gen_left = $urandom;
                gen_right = $urandom;
                push_item(ddo_pkg::ACT_UPDATE, gen_left, gen_right, 1'b1);
            end else if (r < 88) begin
                gen_left = $urandom;
                gen_right = $urandom;
                push_item(ddo_pkg::ACT_LATCH, gen_left, gen_right, 1'b1);
            end else begin
                l = $urandom;
                rr = $urandom;
                push_item(1'($urandom), l, rr, 1'b0);
            end
        end
    endtask

    initial begin
        errors = 0;
        hold_req = 0;
        hold_seen = 0;
        no_idle = 1'b0;
        idle_cycles = 0;
        cfg_we = 1'b0;
        cfg_index = ddo_pkg::REG_ANGLE_PER_MM;
        cfg_wdata = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        action = ddo_pkg::ACT_LATCH;
        left_pos = '0;
        right_pos = '0;
        reads_ok = 1'b0;
        odo_prev_left = '0; odo_prev_right = '0; odo_heading = '0;
        odo_x = '0; odo_y = '0;
        odo_angle_per_mm = '0; odo_left_ref = 1'b0; odo_rate_hz = 10'd50;
        gen_left = '0;
        gen_right = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults first: updates from zeroed positions, no turn
        push_item(ddo_pkg::ACT_UPDATE, 32'd120, 32'd80, 1'b1);
        push_item(ddo_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        drain();

        // Extremes: widest turn gain, left reference, a high rate of 1000 Hz
        configure(40'hFF_FFFF_FFFF, 1'b1, 10'd1000);
        push_item(ddo_pkg::ACT_UPDATE, 32'd5, 32'd7, 1'b0);       // failed read, update
        push_item(ddo_pkg::ACT_LATCH, 32'd999, 32'd999, 1'b0);    // failed read, latch
        push_item(ddo_pkg::ACT_LATCH, 32'd100, 32'd200, 1'b1);
        push_item(ddo_pkg::ACT_UPDATE, 32'd150, 32'd260, 1'b1);
        push_item(ddo_pkg::ACT_UPDATE, 32'd150, 32'd260, 1'b1);   // zero motion
        // wrapped deltas
        push_item(ddo_pkg::ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        push_item(ddo_pkg::ACT_LATCH, 32'd0, 32'd0, 1'b1);
        // saturated turn
        push_item(ddo_pkg::ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        push_item(ddo_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(ddo_pkg::ACT_UPDATE, 32'h0000_0000, 32'h0000_0001, 1'b1);
        drain();

        // Zero gain, right reference, zero rate: no turn and zero speeds
        configure(40'd0, 1'b0, 10'd0);
        push_item(ddo_pkg::ACT_LATCH, 32'd0, 32'd0, 1'b1);
        push_item(ddo_pkg::ACT_UPDATE, 32'd1000, 32'd3000, 1'b1);
        push_item(ddo_pkg::ACT_UPDATE, 32'hFFFF_F000, 32'h0000_1000, 1'b1);
        drain();

        // Gentle steering, as with a half-kilometre track, then wide random gains
        configure(40'd89_600_000, 1'b0, 10'd1);
        push_item(ddo_pkg::ACT_LATCH, 32'd0, 32'd0, 1'b1);
        for (int k = 0; k < 6; k++)
            push_item(ddo_pkg::ACT_UPDATE, 32'(k * 300), 32'(k * 900), 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            configure(40'({$urandom, $urandom} >> $urandom_range(0, 30)), 1'($urandom),
                      10'($urandom_range(1, 1000)));
            no_idle = (p == 2);
            if (p == 4) hold_req++;
            queue_random(80);
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
